### design/lgpc_pkg.sv
// Shared types, codes and reply builders for the light-gun pad responder.
// No dependencies; imported by every module of the block.
`default_nettype none
package lgpc_pkg;

    // Reply geometry
    localparam int ReplyLen = 9;
    localparam int IdxW     = $clog2(ReplyLen);

    // Item kinds
    typedef enum logic [1:0] {
        OP_COMMAND = 2'd0,
        OP_PRESS   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_ANALOG  = 2'd3
    } t_op;

    // Handled command codes
    localparam logic [7:0] CMD_INIT_PRESSURE = 8'h40;
    localparam logic [7:0] CMD_QUERY_MASK    = 8'h41;
    localparam logic [7:0] CMD_POLL          = 8'h42;
    localparam logic [7:0] CMD_SETUP_SWITCH  = 8'h43;
    localparam logic [7:0] CMD_SET_ANALOG    = 8'h44;
    localparam logic [7:0] CMD_IDENT         = 8'h45;
    localparam logic [7:0] CMD_ACTUATOR_INFO = 8'h46;
    localparam logic [7:0] CMD_COMBO_INFO    = 8'h47;
    localparam logic [7:0] CMD_LAYOUT_INFO   = 8'h4C;
    localparam logic [7:0] CMD_VIBRATION_MAP = 8'h4D;
    localparam logic [7:0] CMD_NATIVE_MODE   = 8'h4F;

    // Fixed reply bytes
    localparam logic [7:0] BYTE_HEAD = 8'hff;
    localparam logic [7:0] ID_LIVE   = 8'h63;
    localparam logic [7:0] ID_CONFIG = 8'hf3;
    localparam logic [7:0] BYTE_ACK  = 8'h5a;

    // State reset values
    localparam logic [15:0] BUTTONS_RESET = 16'hffff;
    localparam logic [15:0] POS_H_RESET   = 16'h010d;
    localparam logic [15:0] POS_V_RESET   = 16'h0088;

    // Reply bytes, index 0 goes out first
    typedef logic [ReplyLen-1:0][7:0] t_reply_bytes;

    typedef struct packed {
        logic [15:0] buttons;
        logic [15:0] pos_h;
        logic [15:0] pos_v;
        logic        setup_mode;
    } t_pad_state;

    typedef struct packed {
        logic        btn_press;
        logic        btn_release;
        logic [15:0] mask;
        logic        axis_wr;
        logic        axis_sel;
        logic [7:0]  axis_val;
        logic        setup_wr;
        logic        setup_val;
    } t_state_upd;

    typedef struct packed {
        t_reply_bytes    bytes;
        logic [IdxW-1:0] last_idx;
        logic            bad;
    } t_reply;

    // Config-style reply: ff f3 5a 00 00 b5 b6 b7 b8
    function automatic t_reply_bytes cfg_reply(input logic [7:0] b5, input logic [7:0] b6,
                                               input logic [7:0] b7, input logic [7:0] b8);
        t_reply_bytes r;
        r[0] = BYTE_HEAD;
        r[1] = ID_CONFIG;
        r[2] = BYTE_ACK;
        r[3] = 8'h00;
        r[4] = 8'h00;
        r[5] = b5;
        r[6] = b6;
        r[7] = b7;
        r[8] = b8;
        return r;
    endfunction

    // Live data reply from the current pad state
    function automatic t_reply_bytes live_reply(input t_pad_state s);
        t_reply_bytes r;
        r[0] = BYTE_HEAD;
        r[1] = ID_LIVE;
        r[2] = BYTE_ACK;
        r[3] = s.buttons[7:0];
        r[4] = s.buttons[15:8];
        r[5] = s.pos_h[7:0];
        r[6] = s.pos_h[15:8];
        r[7] = s.pos_v[7:0];
        r[8] = s.pos_v[15:8];
        return r;
    endfunction

endpackage
`default_nettype wire

### design/lightgun_pad_command_responder.sv
// Top level of the light-gun pad responder: input register, state, decoder, output.
// Depends on lgpc_pkg, lgpc_state_regs, lgpc_reply_build, lgpc_serializer.
//
// Light-gun pad responder. Each input transaction is a command packet, a button
// press, a button release or a position change. Press, release and position
// transactions update the button word or the X/Y position and produce no output;
// they never stall in the input register. A command produces a nine-byte reply,
// one byte per output transaction, with o_last_byte on the ninth; an unhandled
// command code produces a single 0xff byte with o_last_byte and o_bad_command set.
// The reply carries the button and position state as it stands after every
// earlier input transaction. A command waits in the input register until the
// output register is free. The output register sends one byte per cycle while it
// is not stalled from downstream; the next command enters it in the cycle its
// predecessor's last byte is taken.
// Command 0x43 sets setup mode to (argument != 0) after its reply is formed.
`default_nettype none
module lightgun_pad_command_responder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [7:0]  i_command_byte,
    input  wire logic [7:0]  i_argument_byte,
    input  wire logic [15:0] i_button_mask,
    input  wire logic        i_axis_select,
    input  wire logic [7:0]  i_axis_value,
    // output channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_reply_byte,
    output logic             o_last_byte,
    output logic             o_bad_command
);
    import lgpc_pkg::*;

    logic        r_in_valid;
    t_op         r_in_op;
    logic [7:0]  r_in_cmd;
    logic [7:0]  r_in_arg;
    logic [15:0] r_in_mask;
    logic        r_in_axis;
    logic [7:0]  r_in_val;

    logic       in_take;
    logic       advance;
    logic       is_cmd;
    logic       ser_free;
    logic       load;
    t_state_upd upd;
    t_pad_state pad_state;
    t_reply     reply;

    // Handshake: a command leaves the input register only into a free output
    assign is_cmd  = (r_in_op == OP_COMMAND);
    assign advance = r_in_valid && (!is_cmd || ser_free);
    assign load    = r_in_valid && is_cmd && ser_free;
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    // Input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Input register payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op   <= t_op'(i_op);
            r_in_cmd  <= i_command_byte;
            r_in_arg  <= i_argument_byte;
            r_in_mask <= i_button_mask;
            r_in_axis <= i_axis_select;
            r_in_val  <= i_axis_value;
        end
    end

    // State updates, applied as the item leaves the input register
    always_comb begin
        upd.btn_press   = advance && (r_in_op == OP_PRESS);
        upd.btn_release = advance && (r_in_op == OP_RELEASE);
        upd.mask        = r_in_mask;
        upd.axis_wr     = advance && (r_in_op == OP_ANALOG);
        upd.axis_sel    = r_in_axis;
        upd.axis_val    = r_in_val;
        upd.setup_wr    = load && (r_in_cmd == CMD_SETUP_SWITCH);
        upd.setup_val   = (r_in_arg != 8'h00);
    end

    lgpc_state_regs u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (upd),
        .o_state (pad_state)
    );

    lgpc_reply_build u_build (
        .i_cmd   (r_in_cmd),
        .i_arg   (r_in_arg),
        .i_state (pad_state),
        .o_reply (reply)
    );

    lgpc_serializer u_ser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_reply       (reply),
        .o_free        (ser_free),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_reply_byte  (o_reply_byte),
        .o_last_byte   (o_last_byte),
        .o_bad_command (o_bad_command)
    );

    // Checks
    a_bad_is_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_command |-> o_last_byte)
        else $error("flagged error byte not marked last");

    a_reply_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_byte |=> o_valid && !o_bad_command)
        else $error("reply packet broken off before its last byte");

    a_noncmd_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !is_cmd |-> !o_stall)
        else $error("state-only transaction held in input register");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> !o_valid || (!i_stall && o_last_byte))
        else $error("new reply loaded over a packet still in flight");

endmodule
`default_nettype wire

### design/lgpc_state_regs.sv
// Pad state registers: button word, positions and setup-mode flag.
// Depends on lgpc_pkg.
`default_nettype none
module lgpc_state_regs (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire lgpc_pkg::t_state_upd i_upd,
    output lgpc_pkg::t_pad_state     o_state
);
    import lgpc_pkg::*;

    logic [15:0] r_buttons, n_buttons;
    logic [15:0] r_pos_h, n_pos_h;
    logic [15:0] r_pos_v, n_pos_v;
    logic        r_setup, n_setup;

    // Next state from the update strobes
    always_comb begin
        n_buttons = r_buttons;
        n_pos_h   = r_pos_h;
        n_pos_v   = r_pos_v;
        n_setup   = r_setup;
        if (i_upd.btn_press) begin
            n_buttons = r_buttons & ~i_upd.mask;
        end
        if (i_upd.btn_release) begin
            n_buttons = r_buttons | i_upd.mask;
        end
        if (i_upd.axis_wr) begin
            if (i_upd.axis_sel) begin
                n_pos_v = {8'h00, i_upd.axis_val};
            end else begin
                n_pos_h = {8'h00, i_upd.axis_val};
            end
        end
        if (i_upd.setup_wr) begin
            n_setup = i_upd.setup_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buttons <= BUTTONS_RESET;
            r_pos_h   <= POS_H_RESET;
            r_pos_v   <= POS_V_RESET;
            r_setup   <= 1'b0;
        end else begin
            r_buttons <= n_buttons;
            r_pos_h   <= n_pos_h;
            r_pos_v   <= n_pos_v;
            r_setup   <= n_setup;
        end
    end

    assign o_state = '{buttons: r_buttons, pos_h: r_pos_h, pos_v: r_pos_v,
                       setup_mode: r_setup};

endmodule
`default_nettype wire

### design/lgpc_reply_build.sv
// Command decoder: builds the reply packet for one command from the pad state.
// Depends on lgpc_pkg.
`default_nettype none
module lgpc_reply_build (
    input  wire logic [7:0]          i_cmd,
    input  wire logic [7:0]          i_arg,
    input  wire lgpc_pkg::t_pad_state i_state,
    output lgpc_pkg::t_reply         o_reply
);
    import lgpc_pkg::*;

    logic arg_nz;
    assign arg_nz = (i_arg != 8'h00);

    // Decode the command into a reply
    always_comb begin
        o_reply.last_idx = IdxW'(ReplyLen - 1);
        o_reply.bad      = 1'b0;
        o_reply.bytes    = cfg_reply(8'h00, 8'h00, 8'h00, 8'h00);
        unique case (i_cmd)
            CMD_INIT_PRESSURE: o_reply.bytes = cfg_reply(8'h02, 8'h00, 8'h00, 8'h5a);
            CMD_QUERY_MASK:    o_reply.bytes = cfg_reply(8'h00, 8'h00, 8'h00, 8'h00);
            CMD_POLL:          o_reply.bytes = live_reply(i_state);
            CMD_SETUP_SWITCH: begin
                // reply follows the flag as it was before this command
                if (i_state.setup_mode) begin
                    o_reply.bytes = cfg_reply(8'h00, 8'h00, 8'h00, 8'h00);
                end else begin
                    o_reply.bytes = live_reply(i_state);
                end
            end
            CMD_SET_ANALOG:    o_reply.bytes = cfg_reply(8'h00, 8'h00, 8'h00, 8'h00);
            CMD_IDENT: begin
                o_reply.bytes    = cfg_reply(8'h00, 8'h02, 8'h01, 8'h00);
                o_reply.bytes[3] = 8'h03;
                o_reply.bytes[4] = 8'h02;
            end
            CMD_ACTUATOR_INFO: begin
                if (arg_nz) begin
                    o_reply.bytes = cfg_reply(8'h01, 8'h01, 8'h01, 8'h14);
                end else begin
                    o_reply.bytes = cfg_reply(8'h01, 8'h02, 8'h00, 8'h0a);
                end
            end
            CMD_COMBO_INFO:    o_reply.bytes = cfg_reply(8'h02, 8'h00, 8'h01, 8'h00);
            CMD_LAYOUT_INFO:
                o_reply.bytes = cfg_reply(8'h00, arg_nz ? 8'h07 : 8'h04, 8'h00, 8'h00);
            CMD_VIBRATION_MAP: o_reply.bytes = cfg_reply(8'hff, 8'hff, 8'hff, 8'hff);
            CMD_NATIVE_MODE:   o_reply.bytes = cfg_reply(8'h00, 8'h00, 8'h00, 8'h5a);
            default: begin
                // unhandled code: single flagged byte
                o_reply.bytes    = '0;
                o_reply.bytes[0] = BYTE_HEAD;
                o_reply.last_idx = '0;
                o_reply.bad      = 1'b1;
            end
        endcase
    end

endmodule
`default_nettype wire

### design/lgpc_serializer.sv
// Output register: holds one reply packet and sends it one byte per transaction.
// Depends on lgpc_pkg.
`default_nettype none
module lgpc_serializer (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire lgpc_pkg::t_reply i_reply,
    output logic                  o_free,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [7:0]            o_reply_byte,
    output logic                  o_last_byte,
    output logic                  o_bad_command
);
    import lgpc_pkg::*;

    logic            r_valid;
    t_reply_bytes    r_bytes;
    logic [IdxW-1:0] r_left;
    logic            r_bad;
    logic            take;
    logic            at_last;

    assign take    = r_valid && !i_stall;
    assign at_last = (r_left == '0);
    // free when empty or the last byte leaves this cycle
    assign o_free  = !r_valid || (take && at_last);

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (take && at_last) begin
            r_valid <= 1'b0;
        end
    end

    // Payload: load a packet or shift out the byte just taken
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_reply.bytes;
            r_left  <= i_reply.last_idx;
            r_bad   <= i_reply.bad;
        end else if (take && !at_last) begin
            r_bytes <= t_reply_bytes'(r_bytes >> 8);
            r_left  <= r_left - IdxW'(1);
        end
    end

    assign o_valid       = r_valid;
    assign o_reply_byte  = r_bytes[0];
    assign o_last_byte   = at_last;
    assign o_bad_command = r_bad;

endmodule
`default_nettype wire
